[hdl/lte_pkg.sv]
// Package: shared constants, types and code conversions of the line text editor.
`default_nettype none
package lte_pkg;

  // Longest line and most lines in the document
  localparam int unsigned LINE_WIDTH = 255;
  localparam int unsigned LINE_LIMIT = 255;

  localparam logic [7:0] LineWidthB = 8'(LINE_WIDTH);
  localparam logic [8:0] LineLimitB = 9'(LINE_LIMIT);

  // Screen codes of the control keys
  localparam logic [7:0] SC_RETURN = 8'(13 + 128);
  localparam logic [7:0] SC_LEFT   = 8'(157 + 64);
  localparam logic [7:0] SC_RIGHT  = 8'(29 + 128);
  localparam logic [7:0] SC_UP     = 8'(145 + 64);
  localparam logic [7:0] SC_DOWN   = 8'(17 + 128);
  localparam logic [7:0] SC_HOME   = 8'(19 + 128);
  localparam logic [7:0] SC_BLANK  = 8'h20;

  localparam int unsigned TXT_AW = 16;
  localparam int unsigned LEN_AW = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_MAKE,
    ST_SHIFT,
    ST_PUT,
    ST_DONE
  } lte_state_e;

  typedef struct packed {
    logic              we;
    logic [TXT_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [TXT_AW-1:0] raddr;
  } lte_txt_req_t;

  typedef struct packed {
    logic              we;
    logic [LEN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [LEN_AW-1:0] raddr;
  } lte_len_req_t;

  typedef struct packed {
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [7:0] lines_used;
    logic [7:0] cursor_line_length;
    logic       status;
    logic       read_valid;
    logic [7:0] read_code;
  } lte_res_t;

  function automatic logic [7:0] lte_to_screen(input logic [7:0] k);
    logic [7:0] r;
    if (k <= 8'h1F) r = k ^ 8'h80;
    else if (k <= 8'h3F) r = k;
    else if (k <= 8'h5F) r = k ^ 8'h40;
    else if (k <= 8'h7F) r = k ^ 8'h20;
    else if (k <= 8'h9F) r = k ^ 8'h40;
    else if (k <= 8'hBF) r = k ^ 8'hC0;
    else r = k ^ 8'h80;
    return r;
  endfunction

  function automatic logic [7:0] lte_to_ascii(input logic [7:0] s);
    logic [7:0] r;
    if (s <= 8'h1F) r = s ^ 8'h40;
    else if (s <= 8'h3F) r = s;
    else if (s <= 8'h5F) r = s ^ 8'h20;
    else if (s <= 8'h7F) r = s ^ 8'h40;
    else if (s <= 8'hBF) r = s ^ 8'h80;
    else if (s <= 8'hDF) r = s ^ 8'h40;
    else r = s ^ 8'h80;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/lte_if.sv]
// Interfaces: request and result channels of the line text editor.
`default_nettype none
interface lte_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key;
  logic [7:0] row;
  logic [7:0] col;

  modport source (output valid, output op, output key, output row, output col, input ready);
  modport sink (input valid, input op, input key, input row, input col, output ready);
endinterface

interface lte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic [7:0] lines_used;
  logic [7:0] cursor_line_length;
  logic       status;
  logic       read_valid;
  logic [7:0] read_code;
  logic [7:0] read_ascii;

  modport source (output valid, output cursor_col, output cursor_row, output lines_used,
                  output cursor_line_length, output status, output read_valid,
                  output read_code, output read_ascii, input ready);
  modport sink (input valid, input cursor_col, input cursor_row, input lines_used,
                input cursor_line_length, input status, input read_valid,
                input read_code, input read_ascii, output ready);
endinterface
`default_nettype wire

[hdl/lte_ram.sv]
// Generic synchronous RAM: one write port, one registered read port.
`default_nettype none
module lte_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/lte_ctrl.sv]
// Sequencer: decodes items, moves the cursor and edits lines in the two memories.
`default_nettype none
module lte_ctrl
  import lte_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lte_in_if.sink      in_i,
  output lte_txt_req_t txt_req_o,
  input  wire logic [7:0] txt_rdata_i,
  output lte_len_req_t len_req_o,
  input  wire logic [7:0] len_rdata_i,
  output lte_res_t    res_o,
  output logic        res_valid_o,
  input  wire logic   res_ready_i
);

  lte_state_e state_q, state_d;
  logic [7:0] cur_col_q, cur_col_d;
  logic [7:0] cur_row_q, cur_row_d;
  logic [7:0] total_q, total_d;
  logic [7:0] cur_len_q, cur_len_d;
  logic [7:0] chr_q, chr_d;
  logic [7:0] rrow_q, rrow_d;
  logic [7:0] rcol_q, rcol_d;
  logic [7:0] mk_tgt_q, mk_tgt_d;
  logic [7:0] t_q, t_d;
  logic [7:0] wt_q, wt_d;
  logic       pend_q, pend_d;
  logic       ins_q, ins_d;
  logic       rd_op_q, rd_op_d;
  logic       status_q, status_d;
  logic       rvalid_q, rvalid_d;
  logic [7:0] rcode_q, rcode_d;

  logic       accept;
  logic [7:0] sc;
  logic [8:0] nr9;
  logic [7:0] right_col;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign sc         = lte_to_screen(in_i.key);
  assign nr9        = {1'b0, cur_row_q} + 9'd1;
  assign right_col  = (cur_col_q == 8'hFF) ? cur_col_q : cur_col_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      total_q   <= '0;
      cur_len_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      total_q   <= total_d;
      cur_len_q <= cur_len_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q    <= chr_d;
    rrow_q   <= rrow_d;
    rcol_q   <= rcol_d;
    mk_tgt_q <= mk_tgt_d;
    t_q      <= t_d;
    wt_q     <= wt_d;
    ins_q    <= ins_d;
    rd_op_q  <= rd_op_d;
    status_q <= status_d;
    rvalid_q <= rvalid_d;
    rcode_q  <= rcode_d;
  end

  always_comb begin
    state_d   = state_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    total_d   = total_q;
    cur_len_d = cur_len_q;
    chr_d     = chr_q;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    mk_tgt_d  = mk_tgt_q;
    t_d       = t_q;
    wt_d      = wt_q;
    pend_d    = pend_q;
    ins_d     = ins_q;
    rd_op_d   = rd_op_q;
    status_d  = status_q;
    rvalid_d  = rvalid_q;
    rcode_d   = rcode_q;
    txt_req_o = '0;
    len_req_o = '0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = 1'b0;
          rvalid_d = 1'b0;
          rcode_d  = SC_BLANK;
          pend_d   = 1'b0;
          if (in_i.op) begin
            rd_op_d         = 1'b1;
            rrow_d          = in_i.row;
            rcol_d          = in_i.col;
            len_req_o.raddr = in_i.row;
            txt_req_o.raddr = {in_i.row, in_i.col};
            state_d         = ST_LEN_RD;
          end else begin
            rd_op_d = 1'b0;
            state_d = ST_DONE;
            case (sc)
              SC_RETURN: begin
                if (nr9 >= LineLimitB) begin
                  status_d = 1'b1;
                end else begin
                  cur_row_d = nr9[7:0];
                  cur_col_d = '0;
                  if (nr9 < {1'b0, total_q}) begin
                    len_req_o.raddr = nr9[7:0];
                    state_d         = ST_LEN_RD;
                  end else begin
                    cur_len_d = '0;
                    mk_tgt_d  = nr9[7:0];
                    ins_d     = 1'b0;
                    state_d   = ST_MAKE;
                  end
                end
              end
              SC_LEFT: begin
                if (cur_col_q != 8'd0) cur_col_d = cur_col_q - 8'd1;
              end
              SC_RIGHT: begin
                if (cur_row_q < total_q) begin
                  cur_col_d = (right_col > cur_len_q) ? cur_len_q : right_col;
                end else begin
                  cur_col_d = '0;
                end
              end
              SC_UP: begin
                if (cur_row_q != 8'd0) begin
                  cur_row_d       = cur_row_q - 8'd1;
                  len_req_o.raddr = cur_row_q - 8'd1;
                  state_d         = ST_LEN_RD;
                end
              end
              SC_DOWN: begin
                if (cur_row_q < total_q) begin
                  cur_row_d = nr9[7:0];
                  if (nr9 < {1'b0, total_q}) begin
                    len_req_o.raddr = nr9[7:0];
                    state_d         = ST_LEN_RD;
                  end else begin
                    cur_col_d = '0;
                    cur_len_d = '0;
                  end
                end
              end
              SC_HOME: begin
                cur_col_d = '0;
              end
              default: begin
                chr_d = sc;
                if ({1'b0, cur_row_q} >= LineLimitB) begin
                  status_d = 1'b1;
                end else if (cur_row_q < total_q) begin
                  if (cur_len_q >= LineWidthB) begin
                    status_d = 1'b1;
                  end else begin
                    cur_col_d = (cur_col_q > cur_len_q) ? cur_len_q : cur_col_q;
                    t_d       = cur_len_q;
                    state_d   = ST_SHIFT;
                  end
                end else begin
                  // cursor sits past the last line: create it empty first
                  cur_len_d = '0;
                  cur_col_d = '0;
                  t_d       = '0;
                  mk_tgt_d  = cur_row_q;
                  ins_d     = 1'b1;
                  state_d   = ST_MAKE;
                end
              end
            endcase
          end
        end
      end

      ST_LEN_RD: begin
        if (rd_op_q) begin
          if ((rrow_q < total_q) && (rcol_q < len_rdata_i)) begin
            rvalid_d = 1'b1;
            rcode_d  = txt_rdata_i;
          end
        end else begin
          cur_len_d = len_rdata_i;
          if (cur_col_q > len_rdata_i) cur_col_d = len_rdata_i;
        end
        state_d = ST_DONE;
      end

      ST_MAKE: begin
        len_req_o.we    = 1'b1;
        len_req_o.waddr = total_q;
        len_req_o.wdata = '0;
        total_d         = total_q + 8'd1;
        if (total_q == mk_tgt_q) begin
          state_d = ins_q ? ST_SHIFT : ST_DONE;
        end
      end

      ST_SHIFT: begin
        // write back the character read last cycle one place to the right
        if (pend_q) begin
          txt_req_o.we    = 1'b1;
          txt_req_o.waddr = {cur_row_q, wt_q};
          txt_req_o.wdata = txt_rdata_i;
        end
        if (t_q > cur_col_q) begin
          txt_req_o.raddr = {cur_row_q, t_q - 8'd1};
          pend_d          = 1'b1;
          wt_d            = t_q;
          t_d             = t_q - 8'd1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        txt_req_o.we    = 1'b1;
        txt_req_o.waddr = {cur_row_q, cur_col_q};
        txt_req_o.wdata = chr_q;
        len_req_o.we    = 1'b1;
        len_req_o.waddr = cur_row_q;
        len_req_o.wdata = cur_len_q + 8'd1;
        cur_len_d       = cur_len_q + 8'd1;
        cur_col_d       = cur_col_q + 8'd1;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.cursor_col         = cur_col_q;
    res_o.cursor_row         = cur_row_q;
    res_o.lines_used         = total_q;
    res_o.cursor_line_length = (cur_row_q < total_q) ? cur_len_q : 8'd0;
    res_o.status             = status_q;
    res_o.read_valid         = rvalid_q;
    res_o.read_code          = rcode_q;
  end

endmodule
`default_nettype wire

[hdl/line_text_editor_engine.sv]
// Top level: line text editor engine with text and line-length memories.
`default_nettype none
// Line text editor engine. The document (up to LINE_LIMIT lines of at most
// LINE_WIDTH screen codes) lives in a 64K x 8 text memory addressed by
// {line, column}, and the line lengths in a 256 x 8 memory; the cursor, the
// line count and the cursor line's length sit in registers. Take one item at a
// time on in_i: op 0 applies a key, op 1 reads one stored character. Every
// item gives exactly one result on out_o, held in an output register so the
// next item can start while the result waits. A read, up, down or return
// onto an existing line takes one memory read turn; left, right, home and an
// ignored key touch no memory; a return that creates lines writes one length
// per new line; an insert creates the line first if needed, then moves the
// rest of the line one character a cycle through the single read and write
// port of the text memory. The input takes its next transfer in the cycle
// after the result is loaded. While the output register still holds a result
// that has not been taken, the finished result waits in the sequencer and the
// input stays stalled for as long as the receiver holds off. No clearing pass
// runs after reset: new lines get their length written to zero when created,
// and text beyond a line's end is never read.
module line_text_editor_engine
  import lte_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lte_in_if.sink    in_i,
  lte_out_if.source out_o
);

  lte_txt_req_t txt_req;
  lte_len_req_t len_req;
  logic [7:0]   txt_rdata;
  logic [7:0]   len_rdata;
  lte_res_t     res;
  logic         res_valid;
  logic         slot_free;

  logic         out_valid_q;
  lte_res_t     res_q;
  logic [7:0]   ascii_q;

  lte_ram #(
    .AW(TXT_AW),
    .DW(8)
  ) u_txt_ram (
    .clk_i  (clk_i),
    .we_i   (txt_req.we),
    .waddr_i(txt_req.waddr),
    .wdata_i(txt_req.wdata),
    .raddr_i(txt_req.raddr),
    .rdata_o(txt_rdata)
  );

  lte_ram #(
    .AW(LEN_AW),
    .DW(8)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_req.we),
    .waddr_i(len_req.waddr),
    .wdata_i(len_req.wdata),
    .raddr_i(len_req.raddr),
    .rdata_o(len_rdata)
  );

  lte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .txt_req_o  (txt_req),
    .txt_rdata_i(txt_rdata),
    .len_req_o  (len_req),
    .len_rdata_i(len_rdata),
    .res_o      (res),
    .res_valid_o(res_valid),
    .res_ready_i(slot_free)
  );

  // The output register is free when empty or when its result transfers now
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload while a result waits; convert the code back to ASCII on load
  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      res_q   <= res;
      ascii_q <= lte_to_ascii(res.read_code);
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.cursor_col         = res_q.cursor_col;
  assign out_o.cursor_row         = res_q.cursor_row;
  assign out_o.lines_used         = res_q.lines_used;
  assign out_o.cursor_line_length = res_q.cursor_line_length;
  assign out_o.status             = res_q.status;
  assign out_o.read_valid         = res_q.read_valid;
  assign out_o.read_code          = res_q.read_code;
  assign out_o.read_ascii         = ascii_q;

endmodule
`default_nettype wire
